FILE: sv/text_line_width_meter_assert.svh
// Assertion macros shared by the text line width meter modules.
`ifndef TEXT_LINE_WIDTH_METER_ASSERT_SVH
`define TEXT_LINE_WIDTH_METER_ASSERT_SVH

// Same-cycle implication, checked at every clock outside reset.
`define TLWM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every clock outside reset.
`define TLWM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/tlwm_pkg.sv
// Shared types, codes and constants of the text line width meter.
`timescale 1ns / 1ps

package tlwm_pkg;

   // Parameter defaults
   localparam int HISTOGRAM_BINS_DEF   = 1024;
   localparam int LINE_NUMBER_BITS_DEF = 24;

   // Field widths
   localparam int REQ_W       = 2;
   localparam int KIND_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int BIN_W       = 10;
   localparam int COL_W       = 10;
   localparam int TAB_W       = 8;
   localparam int LNUM_W      = 24;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   // Tab stop unit: one step per bit of the column
   localparam int DIV_STEPS = COL_W;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_TEXT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_EOF  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_BIN  = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_LINE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EOF  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BIN  = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAB_SIZE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_HIST   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PER_FILE_MAX = 2'd3;

   // Special bytes
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TILDE = 8'h7E;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [BYTE_W-1:0] char_byte;
      logic [BIN_W-1:0]  bin_index;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0]  result_kind;
      logic [LNUM_W-1:0]  line_number;
      logic [COL_W-1:0]   line_width;
      logic               is_wide;
      logic [COL_W-1:0]   widest_so_far;
      logic [COUNT_W-1:0] bin_count;
      logic [COUNT_W-1:0] all_line_count;
      logic [COUNT_W-1:0] wide_line_count;
      logic [COL_W-1:0]   highest_bin;
      logic               last;
   } rsp_payload_type;

   // Tab stop unit command and status
   typedef struct packed {
      logic             start;
      logic [COL_W-1:0] column;
      logic [TAB_W-1:0] tab_size;
   } tab_req_type;

   typedef struct packed {
      logic           done;
      logic [COL_W:0] next_stop;
   } tab_rsp_type;

   // Saturating 32-bit increment
   function automatic logic [COUNT_W-1:0] sat_inc32(input logic [COUNT_W-1:0] value);
      sat_inc32 = (value == {COUNT_W{1'b1}}) ? value : value + 1'b1;
   endfunction

endpackage

FILE: sv/tlwm_tab_unit.sv
// Iterative tab stop unit: restoring remainder, one column bit per cycle.
`timescale 1ns / 1ps
`include "text_line_width_meter_assert.svh"

module tlwm_tab_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  tlwm_pkg::tab_req_type tab_req,
   output tlwm_pkg::tab_rsp_type tab_rsp
);
   import tlwm_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [COL_W-1:0]  shift_ff, shift_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [TAB_W-1:0]  tab_ff, tab_in;
   logic [TAB_W-1:0]  rem_ff, rem_in;
   logic [TAB_W:0]    partial;
   logic [TAB_W+1:0]  trial;

   // Shared compare/subtract: partial remainder against the tab size
   assign partial = {rem_ff, shift_ff[COL_W-1]};
   assign trial   = {1'b0, partial} - {2'b00, tab_ff};

   // Sequencer
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      col_in   = col_ff;
      tab_in   = tab_ff;
      rem_in   = rem_ff;
      if (tab_req.start && !busy_ff) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = tab_req.column;
         col_in   = tab_req.column;
         tab_in   = tab_req.tab_size;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         // keep the partial remainder when the trial subtract goes negative
         rem_in   = trial[TAB_W+1] ? partial[TAB_W-1:0] : trial[TAB_W-1:0];
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      col_ff   <= col_in;
      tab_ff   <= tab_in;
      rem_ff   <= rem_in;
   end

   // Next stop = column rounded down to a stop, plus one tab
   assign tab_rsp.done      = done_ff;
   assign tab_rsp.next_stop = (COL_W+1)'(col_ff) - (COL_W+1)'(rem_ff) + (COL_W+1)'(tab_ff);

   `TLWM_ASSERT_NEXT(a_done_single, done_ff, !done_ff, "tab unit done lasted two cycles")
   `TLWM_ASSERT_NOW(a_done_not_busy, done_ff, !busy_ff, "tab unit done while still busy")
   `TLWM_ASSERT_NOW(a_rem_below_tab, done_ff, rem_ff < tab_ff, "tab remainder not below tab size")

endmodule

FILE: sv/text_line_width_meter.sv
// Top level of the text line width meter: sequencer, statistics and histogram RAM.
//
// Usage
//   req channel: one request per transfer (text byte, end of file, histogram
//   bin read), valid/stall handshake; req_stall is high while a request is
//   being worked on. rsp channel: line reports, end-of-file reports and bin
//   reads leave through a single output register; rsp_stall holds it.
//   csr port: single-cycle writes of threshold, tab size, histogram enable
//   and per-file maximum clear, taken at any time.
// Steps per request
//   plain byte or NUL: taken with no further step. Tab byte with tab stops
//   on: the tab step, until the tab stop unit that produces one remainder
//   bit per cycle over the 10-bit column is done. Newline: a histogram RAM
//   read on the transfer, then the line step: read-modify-write, report. Bin
//   read: the bin step. End of file: a line step for an open line, then EOF.
// Reset
//   After reset the histogram RAM is cleared one bin per cycle, all HIST_DEPTH
//   bins (1024 by default), with req_stall high.
// Stall
//   A request is taken while an earlier result waits; the sequencer then
//   waits in its result step until the output register frees up.
`timescale 1ns / 1ps
`include "text_line_width_meter_assert.svh"

module text_line_width_meter #(
   parameter int HISTOGRAM_BINS   = tlwm_pkg::HISTOGRAM_BINS_DEF,
   parameter int LINE_NUMBER_BITS = tlwm_pkg::LINE_NUMBER_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tlwm_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tlwm_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_wr_en,
   input  logic [tlwm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tlwm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tlwm_pkg::*;

   // Bins above the widest column are never touched
   localparam int HIST_DEPTH  = (HISTOGRAM_BINS < (1 << COL_W)) ? HISTOGRAM_BINS : (1 << COL_W);
   localparam int HADDR_W     = $clog2(HIST_DEPTH);
   localparam int COL_MAX_INT = (HISTOGRAM_BINS - 1 < (1 << COL_W) - 1) ?
                                HISTOGRAM_BINS - 1 : (1 << COL_W) - 1;
   localparam logic [COL_W-1:0] COL_MAX = COL_W'(COL_MAX_INT);
   localparam int LC_W        = (LINE_NUMBER_BITS < LNUM_W) ? LINE_NUMBER_BITS : LNUM_W;
   localparam logic [TAB_W-1:0] TAB_RESET = 8'd8;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_TAB   = 6'b000100,
      S_LINE  = 6'b001000,
      S_EOF   = 6'b010000,
      S_BIN   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [COL_W-1:0] threshold_ff, threshold_in;
   logic [TAB_W-1:0] tab_size_ff, tab_size_in;
   logic             count_hist_ff, count_hist_in;
   logic             per_file_max_ff, per_file_max_in;

   // Line and file state
   logic [COL_W-1:0]   column_now_ff, column_now_in;
   logic [LC_W-1:0]    line_counter_ff, line_counter_in;
   logic               line_silenced_ff, line_silenced_in;
   logic               line_open_ff, line_open_in;
   logic [COL_W-1:0]   widest_ff, widest_in;
   logic [COUNT_W-1:0] wide_total_ff, wide_total_in;
   logic [COUNT_W-1:0] lines_total_ff, lines_total_in;
   logic [COL_W-1:0]   hist_top_ff, hist_top_in;

   // Request held while it is worked on
   logic [REQ_W-1:0]   req_kind_ff, req_kind_in;
   logic [HADDR_W-1:0] bin_addr_ff, bin_addr_in;
   logic               bin_ok_ff, bin_ok_in;

   // Clearing pass
   logic [HADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // Histogram RAM
   logic [COUNT_W-1:0] hist_ram_ff [0:HIST_DEPTH-1];
   logic [COUNT_W-1:0] mem_rdata_ff;
   logic               mem_we;
   logic [HADDR_W-1:0] mem_waddr;
   logic [HADDR_W-1:0] mem_raddr;
   logic [COUNT_W-1:0] mem_wdata;
   logic [HADDR_W-1:0] col_bin;

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type out_data;
   logic            out_load;
   logic            out_free;

   // Tab stop unit
   tab_req_type tab_req;
   tab_rsp_type tab_rsp;

   // Line report values
   logic               req_fire;
   logic               line_wide;
   logic [COL_W-1:0]   widest_new;
   logic [COUNT_W-1:0] wide_total_new;
   logic [COUNT_W-1:0] lines_total_new;
   logic [COL_W-1:0]   hist_top_new;
   logic [COL_W-1:0]   tab_column;
   logic               printable;

   tlwm_tab_unit u_tab_unit (
      .clock   (clock),
      .reset   (reset),
      .tab_req (tab_req),
      .tab_rsp (tab_rsp)
   );

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign col_bin   = column_now_ff[HADDR_W-1:0];
   assign printable = (req_payload.char_byte >= CHAR_SPACE) &&
                      (req_payload.char_byte <= CHAR_TILDE);

   // Saturate the tab stop at the top column
   assign tab_column = (tab_rsp.next_stop > {1'b0, COL_MAX}) ? COL_MAX :
                       tab_rsp.next_stop[COL_W-1:0];

   // Statistics after the pending line is counted
   always_comb begin
      line_wide       = (threshold_ff != '0) && (column_now_ff > threshold_ff);
      wide_total_new  = line_wide ? sat_inc32(wide_total_ff) : wide_total_ff;
      widest_new      = (column_now_ff > widest_ff) ? column_now_ff : widest_ff;
      lines_total_new = lines_total_ff;
      hist_top_new    = hist_top_ff;
      if (count_hist_ff) begin
         lines_total_new = sat_inc32(lines_total_ff);
         hist_top_new    = (column_now_ff > hist_top_ff) ? column_now_ff : hist_top_ff;
      end
   end

   // RAM read address: taken from the request on the transfer cycle
   always_comb begin
      if (state_ff == S_IDLE) begin
         mem_raddr = (req_payload.req_type == REQ_BIN) ?
                     req_payload.bin_index[HADDR_W-1:0] : col_bin;
      end else begin
         mem_raddr = (req_kind_ff == REQ_BIN) ? bin_addr_ff : col_bin;
      end
   end

   // Main sequencer
   always_comb begin
      state_in         = state_ff;
      column_now_in    = column_now_ff;
      line_counter_in  = line_counter_ff;
      line_silenced_in = line_silenced_ff;
      line_open_in     = line_open_ff;
      widest_in        = widest_ff;
      wide_total_in    = wide_total_ff;
      lines_total_in   = lines_total_ff;
      hist_top_in      = hist_top_ff;
      req_kind_in      = req_kind_ff;
      bin_addr_in      = bin_addr_ff;
      bin_ok_in        = bin_ok_ff;
      clr_addr_in      = clr_addr_ff;
      out_load         = 1'b0;
      out_data         = '0;
      tab_req          = '0;
      tab_req.column   = column_now_ff;
      tab_req.tab_size = tab_size_ff;
      mem_we           = 1'b0;
      mem_waddr        = col_bin;
      mem_wdata        = sat_inc32(mem_rdata_ff);

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == HADDR_W'(HIST_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               req_kind_in = req_payload.req_type;
               bin_addr_in = req_payload.bin_index[HADDR_W-1:0];
               bin_ok_in   = (32'(req_payload.bin_index) < 32'(HIST_DEPTH));
               case (req_payload.req_type)
                  REQ_TEXT: begin
                     if (req_payload.char_byte == CHAR_NL) begin
                        if (!line_silenced_ff) begin
                           state_in = S_LINE;
                        end else begin
                           // silenced line: dropped with its newline
                           column_now_in    = '0;
                           line_silenced_in = 1'b0;
                           line_open_in     = 1'b0;
                        end
                     end else begin
                        line_open_in = 1'b1;
                        if (!line_silenced_ff) begin
                           if (req_payload.char_byte == CHAR_NUL) begin
                              line_silenced_in = 1'b1;
                           end else if ((tab_size_ff != '0) &&
                                        (req_payload.char_byte == CHAR_TAB)) begin
                              tab_req.start = 1'b1;
                              state_in      = S_TAB;
                           end else if (printable || (tab_size_ff == '0)) begin
                              if (column_now_ff < COL_MAX) begin
                                 column_now_in = column_now_ff + 1'b1;
                              end
                           end
                        end
                     end
                  end
                  REQ_EOF: begin
                     state_in = (line_open_ff && !line_silenced_ff) ? S_LINE : S_EOF;
                  end
                  REQ_BIN: begin
                     state_in = S_BIN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_TAB: begin
            if (tab_rsp.done) begin
               column_now_in = tab_column;
               state_in      = S_IDLE;
            end
         end

         S_LINE: begin
            if (out_free) begin
               out_load                 = 1'b1;
               out_data.result_kind     = KIND_LINE;
               out_data.line_number     = LNUM_W'(line_counter_ff);
               out_data.line_width      = column_now_ff;
               out_data.is_wide         = line_wide;
               out_data.widest_so_far   = widest_new;
               out_data.all_line_count  = lines_total_new;
               out_data.wide_line_count = wide_total_new;
               out_data.highest_bin     = hist_top_new;
               out_data.last            = (req_kind_ff == REQ_TEXT);
               widest_in      = widest_new;
               wide_total_in  = wide_total_new;
               lines_total_in = lines_total_new;
               hist_top_in    = hist_top_new;
               mem_we         = count_hist_ff;
               if (req_kind_ff == REQ_TEXT) begin
                  if (line_counter_ff != {LC_W{1'b1}}) begin
                     line_counter_in = line_counter_ff + 1'b1;
                  end
                  column_now_in    = '0;
                  line_silenced_in = 1'b0;
                  line_open_in     = 1'b0;
                  state_in         = S_IDLE;
               end else begin
                  state_in = S_EOF;
               end
            end
         end

         S_EOF: begin
            if (out_free) begin
               out_load                 = 1'b1;
               out_data.result_kind     = KIND_EOF;
               out_data.widest_so_far   = widest_ff;
               out_data.all_line_count  = lines_total_ff;
               out_data.wide_line_count = wide_total_ff;
               out_data.highest_bin     = hist_top_ff;
               out_data.last            = 1'b1;
               if (per_file_max_ff) begin
                  widest_in = '0;
               end
               column_now_in    = '0;
               line_counter_in  = LC_W'(1);
               line_silenced_in = 1'b0;
               line_open_in     = 1'b0;
               state_in         = S_IDLE;
            end
         end

         S_BIN: begin
            if (out_free) begin
               out_load                 = 1'b1;
               out_data.result_kind     = KIND_BIN;
               out_data.widest_so_far   = widest_ff;
               out_data.bin_count       = bin_ok_ff ? mem_rdata_ff : '0;
               out_data.all_line_count  = lines_total_ff;
               out_data.wide_line_count = wide_total_ff;
               out_data.highest_bin     = hist_top_ff;
               out_data.last            = 1'b1;
               state_in                 = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      threshold_in    = threshold_ff;
      tab_size_in     = tab_size_ff;
      count_hist_in   = count_hist_ff;
      per_file_max_in = per_file_max_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_THRESHOLD:    threshold_in    = csr_wdata[COL_W-1:0];
            CSR_TAB_SIZE:     tab_size_in     = csr_wdata[TAB_W-1:0];
            CSR_COUNT_HIST:   count_hist_in   = csr_wdata[0];
            CSR_PER_FILE_MAX: per_file_max_in = csr_wdata[0];
            default:          threshold_in    = threshold_ff;
         endcase
      end
   end

   // Output register: holds a result until its transfer
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_addr_ff      <= '0;
         threshold_ff     <= '0;
         tab_size_ff      <= TAB_RESET;
         count_hist_ff    <= 1'b0;
         per_file_max_ff  <= 1'b0;
         column_now_ff    <= '0;
         line_counter_ff  <= LC_W'(1);
         line_silenced_ff <= 1'b0;
         line_open_ff     <= 1'b0;
         widest_ff        <= '0;
         wide_total_ff    <= '0;
         lines_total_ff   <= '0;
         hist_top_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_addr_ff      <= clr_addr_in;
         threshold_ff     <= threshold_in;
         tab_size_ff      <= tab_size_in;
         count_hist_ff    <= count_hist_in;
         per_file_max_ff  <= per_file_max_in;
         column_now_ff    <= column_now_in;
         line_counter_ff  <= line_counter_in;
         line_silenced_ff <= line_silenced_in;
         line_open_ff     <= line_open_in;
         widest_ff        <= widest_in;
         wide_total_ff    <= wide_total_in;
         lines_total_ff   <= lines_total_in;
         hist_top_ff      <= hist_top_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_kind_ff <= req_kind_in;
      bin_addr_ff <= bin_addr_in;
      bin_ok_ff   <= bin_ok_in;
      if (out_load) begin
         rsp_payload_ff <= out_data;
      end
   end

   // Histogram RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_ram_ff[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= hist_ram_ff[mem_raddr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `TLWM_ASSERT_NOW(a_tab_done_in_tab, tab_rsp.done, state_ff == S_TAB, "tab unit finished outside tab step")
   `TLWM_ASSERT_NOW(a_no_overwrite, out_load, !rsp_valid_ff || !rsp_stall, "result register overwritten while held")
   `TLWM_ASSERT_NOW(a_column_max, 1'b1, column_now_ff <= COL_MAX, "column above top bin")
   `TLWM_ASSERT_NEXT(a_newline_reports, req_fire && (req_payload.req_type == REQ_TEXT) && (req_payload.char_byte == CHAR_NL) && !line_silenced_ff, state_ff == S_LINE, "newline did not start a line report")

endmodule
